@@ rtl/core/cma_pkg.sv @@
// Shared definitions for the centred moving average block.
// Holds fixed widths of the stream bookkeeping and the divider request type.
// No dependencies.
package cma_pkg;

	// Width of the configuration register that sets the half window.
	localparam int HW_BITS = 4;

	// Samples of the current stream are counted up to a saturating limit.
	localparam int SEEN_BITS = 6;
	localparam logic [SEEN_BITS-1:0] SEEN_MAX = 6'd63;

	// Request from the sequencer to the serial divider.
	typedef struct packed {
		logic start;
		logic negate;
	} div_req_t;

endpackage

@@ rtl/core/cma_div.sv @@
// Bit-serial restoring divider of a window sum by the number of samples covered.
// Produces one quotient bit per cycle and rounds the signed mean toward zero.
// Depends on cma_pkg for the request type.
module cma_div #(
	parameter int SUM_BITS  = 21,
	parameter int FRAC_BITS = 8,
	parameter int OUT_BITS  = 24,
	parameter int CNT_BITS  = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cma_pkg::div_req_t          req,
	input  logic signed [SUM_BITS-1:0] sum,
	input  logic [CNT_BITS-1:0]        count,
	output logic                       done,
	output logic signed [OUT_BITS-1:0] quotient
);

	localparam int DW       = SUM_BITS + FRAC_BITS;
	localparam int REM_BITS = CNT_BITS + 1;
	localparam int STEP_BITS = $clog2(OUT_BITS);

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_FIX
	} div_state_t;

	div_state_t            state_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [OUT_BITS-1:0]   shift_q;
	logic [CNT_BITS-1:0]   divisor_q;
	logic [STEP_BITS-1:0]  step_q;
	logic                  neg_q;
	logic                  done_q;
	logic signed [OUT_BITS-1:0] quotient_q;

	logic [SUM_BITS-1:0] magnitude;
	logic [DW-1:0]       dividend;
	logic [REM_BITS-1:0] trial;
	logic                fits;

	always_comb begin
		magnitude = sum[SUM_BITS-1] ? (~sum + 1'b1) : sum;
		dividend  = DW'(magnitude) << FRAC_BITS;
		trial     = {rem_q[REM_BITS-2:0], shift_q[OUT_BITS-1]};
		fits      = (trial >= {1'b0, divisor_q});
	end

	// The mean never exceeds the sample range, so the quotient fits in OUT_BITS
	// bits and the dividend bits above that already form a partial remainder
	// smaller than the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						rem_q     <= REM_BITS'(dividend >> OUT_BITS);
						shift_q   <= dividend[OUT_BITS-1:0];
						divisor_q <= count;
						neg_q     <= req.negate;
						step_q    <= STEP_BITS'(OUT_BITS - 1);
						state_q   <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q   <= fits ? (trial - {1'b0, divisor_q}) : trial;
					shift_q <= {shift_q[OUT_BITS-2:0], fits};
					step_q  <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					quotient_q <= neg_q ? signed'(~shift_q + 1'b1) : signed'(shift_q);
					done_q     <= 1'b1;
					state_q    <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign quotient = quotient_q;

endmodule

@@ rtl/core/centered_moving_average.sv @@
// Top level of the centred moving average with truncated stream edges.
// Depends on cma_pkg and on the serial divider cma_div.
//
// Usage: samples arrive on the in_valid/in_ready channel with last_in marking
// the final sample of a stream. For each stream position the block returns the
// mean of the samples from half_window before to half_window after, with the
// window cut short at both stream ends, on the out_valid/out_ready channel.
// Results lag half_window samples behind the input; the transaction carrying
// last_in flushes every pending position, the final one flagged by last_out.
// half_window is written through half_window_we and is taken as K_MAX when
// larger; write it only while the block is idle.
// Timing: each result sums the samples of its window (2*half_window+1 inside
// a long stream) one stored sample per cycle, and the serial divider forms
// its quotient one bit per cycle; these two set the rate. A flush produces
// up to half_window+1 results back to back in that manner.
// A new sample is taken once the previous one's results are computed, even if
// the last result still waits in the output register for the receiver.
// Reset clears the stream position, sets half_window to 1 and empties the
// output register. A stalled receiver holds the result and the block waits.
module centered_moving_average #(
	parameter int K_MAX       = 15,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    half_window_we,
	input  logic [cma_pkg::HW_BITS-1:0]             half_window,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [SAMPLE_BITS-1:0]           sample,
	input  logic                                    last_in,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] average,
	output logic                                    last_out
);

	localparam int WIN_DEPTH = 2 * K_MAX + 1;
	localparam int IDX_BITS  = $clog2(WIN_DEPTH);
	localparam int CNT_BITS  = $clog2(WIN_DEPTH + 1);
	localparam int K_BITS    = $clog2(K_MAX + 1);
	localparam int SUM_BITS  = SAMPLE_BITS + IDX_BITS;
	localparam int OUT_BITS  = SAMPLE_BITS + FRAC_BITS;
	localparam int SB        = cma_pkg::SEEN_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_SUM,
		S_GO,
		S_DIV,
		S_PUT
	} state_t;

	state_t                         state_q;
	logic [cma_pkg::HW_BITS-1:0]    half_window_q;
	logic signed [SAMPLE_BITS-1:0]  window_q [WIN_DEPTH];
	logic [SB-1:0]                  seen_q;
	logic [K_BITS-1:0]              k_q;
	logic [K_BITS-1:0]              dp_q;
	logic                           last_q;
	logic [IDX_BITS-1:0]            idx_q;
	logic [CNT_BITS-1:0]            cnt_q;
	logic signed [SUM_BITS-1:0]     acc_q;
	logic                           out_valid_q;
	logic signed [OUT_BITS-1:0]     average_q;
	logic                           last_out_q;

	logic                       in_fire;
	logic                       out_free;
	logic [SB-1:0]              seen_next;
	logic [SB-1:0]              k_eff;
	logic [SB-1:0]              first_dp;
	logic                       emit_now;
	logic [SB-1:0]              k_ext;
	logic [SB-1:0]              dp_ext;
	logic [SB-1:0]              avail;
	logic [SB-1:0]              left;
	logic [CNT_BITS-1:0]        count_calc;
	logic                       sum_end;
	cma_pkg::div_req_t          div_req;
	logic                       div_done;
	logic signed [OUT_BITS-1:0] div_quotient;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		seen_next = (seen_q == cma_pkg::SEEN_MAX) ? seen_q : seen_q + 1'b1;
		k_eff     = (SB'(half_window_q) > SB'(K_MAX)) ? SB'(K_MAX) : SB'(half_window_q);
		// On the final sample the flush starts at the oldest position still
		// pending, which for a short stream is its very first sample.
		first_dp  = (last_in && (seen_next - 1'b1 < k_eff)) ? seen_next - 1'b1 : k_eff;
		emit_now  = last_in || (seen_next > k_eff);

		k_ext      = SB'(k_q);
		dp_ext     = SB'(dp_q);
		avail      = seen_q - 1'b1 - dp_ext;
		left       = ((seen_q != cma_pkg::SEEN_MAX) && (avail < k_ext)) ? avail : k_ext;
		count_calc = CNT_BITS'(dp_ext + 1'b1 + left);

		sum_end = (CNT_BITS'(idx_q) == cnt_q - 1'b1);

		div_req.start  = (state_q == S_GO);
		div_req.negate = acc_q[SUM_BITS-1];
	end

	// Shift line of the stream, newest sample at entry 0.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			window_q[0] <= sample;
			for (int i = 1; i < WIN_DEPTH; i++) begin
				window_q[i] <= window_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q <= cma_pkg::HW_BITS'(1);
		end else if (half_window_we) begin
			half_window_q <= half_window;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_PUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						seen_q <= seen_next;
						k_q    <= K_BITS'(k_eff);
						dp_q   <= K_BITS'(first_dp);
						last_q <= last_in;
						if (emit_now) begin
							state_q <= S_CALC;
						end
					end
				end
				S_CALC: begin
					cnt_q   <= count_calc;
					idx_q   <= '0;
					acc_q   <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q <= acc_q + SUM_BITS'(window_q[idx_q]);
					idx_q <= idx_q + 1'b1;
					if (sum_end) begin
						state_q <= S_GO;
					end
				end
				S_GO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						average_q   <= div_quotient;
						last_out_q  <= last_q && (dp_q == '0);
						if (last_q && (dp_q != '0)) begin
							dp_q    <= dp_q - 1'b1;
							state_q <= S_CALC;
						end else begin
							if (last_q) begin
								seen_q <= '0;
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	cma_div #(
		.SUM_BITS  (SUM_BITS),
		.FRAC_BITS (FRAC_BITS),
		.OUT_BITS  (OUT_BITS),
		.CNT_BITS  (CNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.sum      (acc_q),
		.count    (cnt_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign last_out  = last_out_q;

endmodule

@@ verif/cma_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the centred moving average block: watches both channels,
// predicts every window mean and compares it with what the block returns.
// Depends on cma_pkg for the register width and the stream counter limit.
module cma_checker #(
	parameter int K_MAX       = 15,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    half_window_we,
	input  logic [cma_pkg::HW_BITS-1:0]             half_window,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic signed [SAMPLE_BITS-1:0]           sample,
	input  logic                                    last_in,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic signed [SAMPLE_BITS+FRAC_BITS-1:0] average,
	input  logic                                    last_out,
	output int                                      mismatches,
	output int                                      means_pending,
	output int                                      means_checked
);

	localparam int DEPTH    = 2 * K_MAX + 1;
	localparam int OUT_BITS = SAMPLE_BITS + FRAC_BITS;

	typedef struct {
		logic signed [OUT_BITS-1:0] avg;
		logic                       last;
	} mean_t;

	mean_t                         expected_means[$];
	logic signed [SAMPLE_BITS-1:0] history [DEPTH];
	logic [cma_pkg::HW_BITS-1:0]   hw_reg;
	int                            stream_len;
	int                            err_count;
	int                            checked;

	// Mean of history entries first..first+count-1, truncated toward zero.
	function automatic logic signed [OUT_BITS-1:0] window_mean(int first, int count);
		longint acc;
		longint quot;
		acc = 0;
		for (int d = first; d < first + count && d < DEPTH; d++)
			acc += history[d];
		quot = (acc * (longint'(1) << FRAC_BITS)) / longint'(count);
		return quot[OUT_BITS-1:0];
	endfunction

	// Queues the mean for the position dp samples behind the newest one.
	task automatic queue_mean(int dp, int k, bit right_cut, bit is_last);
		int    right;
		int    left;
		int    pos;
		mean_t m;
		right = right_cut ? dp : k;
		left  = k;
		// Once the counter saturates the left side is always full.
		if (stream_len < int'(cma_pkg::SEEN_MAX)) begin
			pos = stream_len - 1 - dp;
			if (pos < k)
				left = pos;
		end
		m.avg  = window_mean(dp - right, right + 1 + left);
		m.last = is_last;
		expected_means.push_back(m);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		mean_t want;
		int    k;
		int    dp;
		if (!arst_n) begin
			expected_means.delete();
			foreach (history[i])
				history[i] = '0;
			hw_reg     = cma_pkg::HW_BITS'(1);
			stream_len = 0;
			err_count  = 0;
			checked    = 0;
		end else begin
			if (half_window_we)
				hw_reg = half_window;

			if (out_valid && out_ready) begin
				checked++;
				if (expected_means.size() == 0) begin
					err_count++;
					$error("unexpected result: average %0d, last_out %0b", average, last_out);
				end else begin
					want = expected_means.pop_front();
					if (average !== want.avg) begin
						err_count++;
						$error("average: expected %0d, got %0d", want.avg, average);
					end
					if (last_out !== want.last) begin
						err_count++;
						$error("last_out: expected %0b, got %0b", want.last, last_out);
					end
				end
			end

			if (in_valid && in_ready) begin
				k = (int'(hw_reg) > K_MAX) ? K_MAX : int'(hw_reg);
				for (int i = DEPTH - 1; i > 0; i--)
					history[i] = history[i-1];
				history[0] = sample;
				if (stream_len < int'(cma_pkg::SEEN_MAX))
					stream_len++;
				if (!last_in) begin
					if (stream_len >= k + 1)
						queue_mean(k, k, 1'b0, 1'b0);
				end else begin
					// The final sample flushes every position still waiting.
					dp = (stream_len - 1 < k) ? stream_len - 1 : k;
					for (; dp >= 0; dp--)
						queue_mean(dp, k, 1'b1, dp == 0);
					stream_len = 0;
				end
			end
		end
		mismatches    <= err_count;
		means_pending <= expected_means.size();
		means_checked <= checked;
	end

endmodule

@@ verif/centered_moving_average_tb.sv @@
`timescale 1ns / 100ps
// Top of the centred moving average testbench: clock, reset, sample streams,
// half window changes and the final verdict. Depends on cma_pkg, the block
// itself and cma_checker, which does all prediction and comparison.
module centered_moving_average_tb;

	localparam int K_MAX       = 15;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int DRAIN_WAIT  = 80;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 290;

	logic                                    clk;
	logic                                    arst_n;
	logic                                    half_window_we;
	logic [cma_pkg::HW_BITS-1:0]             half_window;
	logic                                    in_valid;
	logic                                    in_ready;
	logic signed [SAMPLE_BITS-1:0]           sample;
	logic                                    last_in;
	logic                                    out_valid;
	logic                                    out_ready = 1'b0;
	logic signed [SAMPLE_BITS+FRAC_BITS-1:0] average;
	logic                                    last_out;

	int  mismatches;
	int  means_pending;
	int  means_checked;
	int  cycles = 0;
	int  samples_sent = 0;
	int  streams_sent = 0;
	int  settings_used = 1;
	int  stall_left = 0;
	bit  steady_in = 0;
	bit  steady_out = 0;

	centered_moving_average #(
		.K_MAX(K_MAX),
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.half_window_we(half_window_we),
		.half_window(half_window),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average(average),
		.last_out(last_out)
	);

	cma_checker #(
		.K_MAX(K_MAX),
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.half_window_we(half_window_we),
		.half_window(half_window),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average(average),
		.last_out(last_out),
		.mismatches(mismatches),
		.means_pending(means_pending),
		.means_checked(means_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Mostly short pauses, now and then a long one.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 3);
		else if (r < 18)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_sample();
		case ($urandom_range(0, 9))
			0:       return -32768;
			1:       return 32767;
			2, 3:    return int'($urandom_range(0, 200)) - 100;
			default: return int'($urandom);
		endcase
	endfunction

	// Receiver back-pressure.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady_out && $urandom_range(0, 3) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= pause_len();
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send(int value, logic is_last);
		int gap;
		gap = (steady_in || $urandom_range(0, 9) < 4) ? 0 : pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= SAMPLE_BITS'(value);
		last_in  <= is_last;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
		if (is_last)
			streams_sent++;
	endtask

	// Lets every expected mean arrive and the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (means_pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_half_window(int value);
		drain();
		half_window_we <= 1'b1;
		half_window    <= cma_pkg::HW_BITS'(value);
		@(posedge clk);
		half_window_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int len;
		int idx;
		arst_n         = 1'b0;
		half_window_we = 1'b0;
		half_window    = '0;
		in_valid       = 1'b0;
		sample         = '0;
		last_in        = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset half window of one: full-scale values and mixed signs.
		steady_out = 1;
		send(32767, 1'b0); send(32767, 1'b0); send(32767, 1'b1);
		send(-32768, 1'b0); send(-32768, 1'b0); send(-32768, 1'b0); send(-32768, 1'b1);
		send(-32768, 1'b0); send(32767, 1'b0); send(0, 1'b0); send(-1, 1'b0);
		send(1, 1'b1);
		// A stream of a single sample.
		send(5, 1'b1);
		steady_out = 0;
		// Stream shorter than the half window.
		set_half_window(K_MAX);
		send(100, 1'b0); send(-7, 1'b0); send(32767, 1'b1);
		// No neighbours at all: each mean is the sample itself.
		set_half_window(0);
		send(-32768, 1'b0); send(32767, 1'b0); send(-3, 1'b1);

		idx = 0;
		while (samples_sent < RANDOM_ITEMS + 19) begin
			if (idx == 2) begin
				// Long enough for the stream counter to saturate.
				set_half_window(K_MAX);
				len = 75;
			end else begin
				if (idx % 4 == 0) begin
					case ($urandom_range(0, 3))
						0:       set_half_window(0);
						1:       set_half_window(K_MAX);
						default: set_half_window($urandom_range(0, K_MAX));
					endcase
				end
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
				                                  : $urandom_range(4, 24);
			end
			steady_in  = ($urandom_range(0, 4) == 0);
			steady_out = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++)
				send(pick_sample(), i == len - 1);
			idx++;
		end
		steady_in  = 0;
		steady_out = 0;
		drain();

		$display("%0d samples in %0d streams under %0d half window settings,",
		         samples_sent, streams_sent, settings_used);
		$display("%0d window means compared, %0d mismatches", means_checked, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
